@@ rtl/dapc_pkg.sv @@
// shared types and constants of the dual axis clamped pid controller
`timescale 1ns / 1ps

package dapc_pkg;

  localparam int PosW    = 16;
  localparam int ErrW    = 17;
  localparam int IntegW  = 22;
  localparam int DerivW  = 18;
  localparam int GainW   = 18;
  localparam int ILimW   = 21;
  localparam int OLimW   = 15;
  localparam int DriveW  = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 21;
  localparam int FracW   = 16;

  localparam int ProdPW = ErrW + GainW + 1;
  localparam int ProdIW = IntegW + GainW + 1;
  localparam int ProdDW = DerivW + GainW + 1;
  localparam int AccW   = ProdIW + 2;
  localparam int ShW    = AccW - FracW;

  localparam logic [GainW-1:0] GainPRst  = GainW'(52429);
  localparam logic [GainW-1:0] GainIRst  = GainW'(13);
  localparam logic [GainW-1:0] GainDRst  = GainW'(110100);
  localparam logic [ILimW-1:0] ILimRst   = ILimW'(2048000);
  localparam logic [OLimW-1:0] OLimRst   = OLimW'(4096);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_INTEG_LIM  = 3'd3,
    CFG_OUTPUT_LIM = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [GainW-1:0] gain_p;
    logic [GainW-1:0] gain_i;
    logic [GainW-1:0] gain_d;
    logic [ILimW-1:0] integ_lim;
    logic [OLimW-1:0] output_lim;
  } cfg_t;

  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld4;
  } ctrl_t;

endpackage

@@ rtl/dapc_axis.sv @@
// one pid axis: error, clamped integral, derivative, products and clamped drive
`timescale 1ns / 1ps

module dapc_axis (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dapc_pkg::ctrl_t               ctrl_i,
  input  dapc_pkg::cfg_t                cfg_i,
  input  logic [dapc_pkg::PosW-1:0]     pos_i,
  output logic [dapc_pkg::DriveW-1:0]   drive_o
);

  // loop state
  logic signed [dapc_pkg::IntegW-1:0] integ_q, integ_d;
  logic signed [dapc_pkg::ErrW-1:0]   hist1_q, hist2_q;

  // stage registers
  logic signed [dapc_pkg::ErrW-1:0]   err_s1_q, err_s1_d;
  logic signed [dapc_pkg::ErrW-1:0]   p_s2_q;
  logic signed [dapc_pkg::IntegW-1:0] i_s2_q;
  logic signed [dapc_pkg::DerivW-1:0] d_s2_q, deriv_d;
  logic signed [dapc_pkg::ProdPW-1:0] prod_p_q, prod_p_d;
  logic signed [dapc_pkg::ProdIW-1:0] prod_i_q, prod_i_d;
  logic signed [dapc_pkg::ProdDW-1:0] prod_d_q, prod_d_d;
  logic [dapc_pkg::DriveW-1:0]        drive_q, drive_d;

  logic signed [dapc_pkg::PosW:0]     pos_ext;
  logic signed [dapc_pkg::IntegW:0]   integ_sum;
  logic signed [dapc_pkg::IntegW:0]   ilim_pos, ilim_neg;
  logic signed [dapc_pkg::GainW:0]    gp_s, gi_s, gd_s;
  logic signed [dapc_pkg::AccW-1:0]   acc;
  logic signed [dapc_pkg::ShW-1:0]    acc_sh, olim_pos, olim_neg, drive_sat;

  // error is the negated offset
  always_comb begin
    pos_ext  = $signed({pos_i[dapc_pkg::PosW-1], pos_i});
    err_s1_d = -pos_ext;
  end

  // integral with clamp, derivative against error two samples back
  always_comb begin
    integ_sum = $signed({integ_q[dapc_pkg::IntegW-1], integ_q})
              + $signed({{(dapc_pkg::IntegW+1-dapc_pkg::ErrW){err_s1_q[dapc_pkg::ErrW-1]}},
                         err_s1_q});
    ilim_pos  = $signed({2'b00, cfg_i.integ_lim});
    ilim_neg  = -ilim_pos;
    if (integ_sum > ilim_pos) begin
      integ_d = ilim_pos[dapc_pkg::IntegW-1:0];
    end else if (integ_sum < ilim_neg) begin
      integ_d = ilim_neg[dapc_pkg::IntegW-1:0];
    end else begin
      integ_d = integ_sum[dapc_pkg::IntegW-1:0];
    end
    deriv_d = $signed({err_s1_q[dapc_pkg::ErrW-1], err_s1_q})
            - $signed({hist2_q[dapc_pkg::ErrW-1], hist2_q});
  end

  // gain products
  always_comb begin
    gp_s     = $signed({1'b0, cfg_i.gain_p});
    gi_s     = $signed({1'b0, cfg_i.gain_i});
    gd_s     = $signed({1'b0, cfg_i.gain_d});
    prod_p_d = p_s2_q * gp_s;
    prod_i_d = i_s2_q * gi_s;
    prod_d_d = d_s2_q * gd_s;
  end

  // sum, floor shift and output clamp
  always_comb begin
    acc = $signed({{(dapc_pkg::AccW-dapc_pkg::ProdPW){prod_p_q[dapc_pkg::ProdPW-1]}},
                   prod_p_q})
        + $signed({{(dapc_pkg::AccW-dapc_pkg::ProdIW){prod_i_q[dapc_pkg::ProdIW-1]}},
                   prod_i_q})
        + $signed({{(dapc_pkg::AccW-dapc_pkg::ProdDW){prod_d_q[dapc_pkg::ProdDW-1]}},
                   prod_d_q});
    acc_sh   = acc[dapc_pkg::AccW-1:dapc_pkg::FracW];
    olim_pos = $signed({{(dapc_pkg::ShW-dapc_pkg::OLimW){1'b0}}, cfg_i.output_lim});
    olim_neg = -olim_pos;
    if (acc_sh > olim_pos) begin
      drive_sat = olim_pos;
    end else if (acc_sh < olim_neg) begin
      drive_sat = olim_neg;
    end else begin
      drive_sat = acc_sh;
    end
    drive_d = drive_sat[dapc_pkg::DriveW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      hist1_q <= '0;
      hist2_q <= '0;
    end else if (ctrl_i.ld2) begin
      integ_q <= integ_d;
      hist2_q <= hist1_q;
      hist1_q <= err_s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.ld1) begin
      err_s1_q <= err_s1_d;
    end
    if (ctrl_i.ld2) begin
      p_s2_q <= err_s1_q;
      i_s2_q <= integ_d;
      d_s2_q <= deriv_d;
    end
    if (ctrl_i.ld3) begin
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
      prod_d_q <= prod_d_d;
    end
    if (ctrl_i.ld4) begin
      drive_q <= drive_d;
    end
  end

  assign drive_o = drive_q;

endmodule

@@ rtl/dual_axis_pid_clamped.sv @@
// top level of the dual axis pid controller: config registers, stage control, two axes
//
//  channel  direction  handshake               payload
//  in       input      in_valid_i / in_ready_o   pos_x_i, pos_y_i
//  out      output     out_valid_o / out_ready_i drive_x_o, drive_y_o
//  cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// four register stages: error, integral and derivative, gain products, sum and clamp
// one transaction per cycle sustained while out_ready_i stays high
// the integral loop closes in the second stage, so samples may follow each cycle
// each stage takes a new transaction while it is empty or its successor moves on
// reset clears all stage valids, the loop state and loads the default config
`timescale 1ns / 1ps

module dual_axis_pid_clamped (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [dapc_pkg::PosW-1:0]      pos_x_i,
  input  logic [dapc_pkg::PosW-1:0]      pos_y_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [dapc_pkg::DriveW-1:0]    drive_x_o,
  output logic [dapc_pkg::DriveW-1:0]    drive_y_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dapc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dapc_pkg::CfgDatW-1:0]   cfg_data_i
);

  dapc_pkg::cfg_t  cfg_q;
  dapc_pkg::ctrl_t ctrl;

  logic v1_q, v2_q, v3_q, v4_q;
  logic v1_d, v2_d, v3_d, v4_d;
  logic rdy1, rdy2, rdy3, rdy4;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= dapc_pkg::GainPRst;
      cfg_q.gain_i     <= dapc_pkg::GainIRst;
      cfg_q.gain_d     <= dapc_pkg::GainDRst;
      cfg_q.integ_lim  <= dapc_pkg::ILimRst;
      cfg_q.output_lim <= dapc_pkg::OLimRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dapc_pkg::cfg_idx_e'(cfg_index_i))
        dapc_pkg::CFG_GAIN_P:     cfg_q.gain_p     <= cfg_data_i[dapc_pkg::GainW-1:0];
        dapc_pkg::CFG_GAIN_I:     cfg_q.gain_i     <= cfg_data_i[dapc_pkg::GainW-1:0];
        dapc_pkg::CFG_GAIN_D:     cfg_q.gain_d     <= cfg_data_i[dapc_pkg::GainW-1:0];
        dapc_pkg::CFG_INTEG_LIM:  cfg_q.integ_lim  <= cfg_data_i[dapc_pkg::ILimW-1:0];
        dapc_pkg::CFG_OUTPUT_LIM: cfg_q.output_lim <= cfg_data_i[dapc_pkg::OLimW-1:0];
        default: begin
        end
      endcase
    end
  end

  // ready ripples back from the output register
  always_comb begin
    rdy4 = !v4_q || out_ready_i;
    rdy3 = !v3_q || rdy4;
    rdy2 = !v2_q || rdy3;
    rdy1 = !v1_q || rdy2;
    ctrl.ld1 = in_valid_i && rdy1;
    ctrl.ld2 = v1_q && rdy2;
    ctrl.ld3 = v2_q && rdy3;
    ctrl.ld4 = v3_q && rdy4;
    v1_d = rdy1 ? in_valid_i : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
    v3_d = rdy3 ? v2_q : v3_q;
    v4_d = rdy4 ? v3_q : v4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      v4_q <= v4_d;
    end
  end

  dapc_axis u_axis_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .pos_i   (pos_x_i),
    .drive_o (drive_x_o)
  );

  dapc_axis u_axis_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .cfg_i   (cfg_q),
    .pos_i   (pos_y_i),
    .drive_o (drive_y_o)
  );

  assign in_ready_o  = rdy1;
  assign out_valid_o = v4_q;

`ifndef NO_ASSERTIONS
  a_full_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v1_q && v2_q && v3_q && v4_q && !out_ready_i))
    else $error("input blocked while a stage is free");

  a_stage2_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ld2 |=> v2_q)
    else $error("stage two lost a transaction");

  a_result_arrives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !v4_q) |=> v4_q)
    else $error("stage three did not reach the output register");

  a_output_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && !out_ready_i) |=> (v4_q && $stable(drive_x_o) && $stable(drive_y_o)))
    else $error("stalled result changed");
`endif

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the dual axis clamped pid controller
`timescale 1ns / 1ps

module testbench;

  localparam int PosW    = dapc_pkg::PosW;
  localparam int ErrW    = dapc_pkg::ErrW;
  localparam int IntegW  = dapc_pkg::IntegW;
  localparam int DriveW  = dapc_pkg::DriveW;
  localparam int GainW   = dapc_pkg::GainW;
  localparam int ILimW   = dapc_pkg::ILimW;
  localparam int OLimW   = dapc_pkg::OLimW;
  localparam int CfgIdxW = dapc_pkg::CfgIdxW;
  localparam int CfgDatW = dapc_pkg::CfgDatW;
  localparam int FracW   = dapc_pkg::FracW;

  localparam int StuckLimit = 2000;
  localparam int RandomSamples = 1630;
  localparam int RandomPhases = 11;
  localparam logic [CfgIdxW-1:0] CfgIdxFirstSpare = CfgIdxW'(dapc_pkg::CFG_OUTPUT_LIM + 1);
  localparam int unsigned GainMax = (1 << GainW) - 1;
  localparam int unsigned ILimMax = (1 << ILimW) - 1;
  localparam int unsigned OLimMax = (1 << OLimW) - 1;

  typedef struct {
    logic signed [IntegW-1:0] integ;
    logic signed [ErrW-1:0]   err1;
    logic signed [ErrW-1:0]   err2;
  } axis_hist_t;

  typedef struct {
    logic [DriveW-1:0] dx;
    logic [DriveW-1:0] dy;
  } drive_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [PosW-1:0] pos_x_i;
  logic [PosW-1:0] pos_y_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [DriveW-1:0] drive_x_o;
  logic [DriveW-1:0] drive_y_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [CfgDatW-1:0] cfg_data_i;

  logic [GainW-1:0] cfg_kp;
  logic [GainW-1:0] cfg_ki;
  logic [GainW-1:0] cfg_kd;
  logic [ILimW-1:0] cfg_ilim;
  logic [OLimW-1:0] cfg_olim;
  axis_hist_t hist_x;
  axis_hist_t hist_y;
  drive_pair_t drive_q[$];
  logic [PosW-1:0] walk_x = '0;
  logic [PosW-1:0] walk_y = '0;

  bit bursty = 1'b0;
  int fail_cnt = 0;
  int sample_cnt = 0;
  int result_cnt = 0;
  int cfg_write_cnt = 0;
  int stuck_cycles = 0;

  dual_axis_pid_clamped dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [DriveW-1:0] pid_axis_step(inout axis_hist_t h,
                                                      input logic [PosW-1:0] pos);
    longint e, s, d, acc, lim, olim, drv;
    e = -longint'($signed(pos));
    lim = longint'(cfg_ilim);
    olim = longint'(cfg_olim);
    s = longint'(h.integ) + e;
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    d = e - longint'(h.err2);
    h.integ = IntegW'(s);
    h.err2 = h.err1;
    h.err1 = ErrW'(e);
    acc = e * longint'(cfg_kp) + s * longint'(cfg_ki) + d * longint'(cfg_kd);
    drv = acc >>> FracW;
    if (drv > olim) drv = olim;
    if (drv < -olim) drv = -olim;
    return DriveW'(drv);
  endfunction

  function automatic int idle_gap();
    int r;
    if (!bursty) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [PosW-1:0] rand_pos(inout logic [PosW-1:0] walk);
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      v = int'($urandom_range(0, 4000)) - 2000;
      return PosW'(v);
    end
    if (r < 60) return PosW'($urandom);
    if (r < 70) begin
      case ($urandom_range(0, 4))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'hffff;
        3: return 16'h0001;
        default: return '0;
      endcase
    end
    v = int'($urandom_range(0, 64)) - 32;
    walk = walk + PosW'(v);
    return walk;
  endfunction

  function automatic int unsigned pick_reg(int unsigned maxv, int unsigned rstv);
    case ($urandom_range(0, 9))
      0: return 0;
      1: return maxv;
      2: return rstv;
      3, 4, 5: return $urandom_range(0, maxv);
      default: return $urandom_range(0, maxv / 16);
    endcase
  endfunction

  task automatic send_sample(input logic [PosW-1:0] px, input logic [PosW-1:0] py);
    int gap;
    drive_pair_t want;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= px;
    pos_y_i <= py;
    do @(posedge clk_i); while (!in_ready_o);
    want.dx = pid_axis_step(hist_x, px);
    want.dy = pid_axis_step(hist_y, py);
    drive_q.push_back(want);
    sample_cnt++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      dapc_pkg::CFG_GAIN_P:     cfg_kp = data[GainW-1:0];
      dapc_pkg::CFG_GAIN_I:     cfg_ki = data[GainW-1:0];
      dapc_pkg::CFG_GAIN_D:     cfg_kd = data[GainW-1:0];
      dapc_pkg::CFG_INTEG_LIM:  cfg_ilim = data[ILimW-1:0];
      dapc_pkg::CFG_OUTPUT_LIM: cfg_olim = data[OLimW-1:0];
      default: ;
    endcase
    cfg_write_cnt++;
    @(posedge clk_i);
  endtask

  // noisy writes put random junk above the register width, except for the integral limit
  task automatic apply_config(input int unsigned gp, input int unsigned gi,
                              input int unsigned gd, input int unsigned il,
                              input int unsigned ol, input bit noisy);
    logic [CfgDatW-1:0] junk;
    junk = noisy ? CfgDatW'($urandom) : '0;
    write_reg(dapc_pkg::CFG_GAIN_P, ((junk >> GainW) << GainW) | CfgDatW'(gp));
    write_reg(dapc_pkg::CFG_GAIN_I, ((junk >> GainW) << GainW) | CfgDatW'(gi));
    write_reg(dapc_pkg::CFG_GAIN_D, ((junk >> GainW) << GainW) | CfgDatW'(gd));
    write_reg(dapc_pkg::CFG_INTEG_LIM, CfgDatW'(il));
    write_reg(dapc_pkg::CFG_OUTPUT_LIM, ((junk >> OLimW) << OLimW) | CfgDatW'(ol));
    if (noisy && $urandom_range(0, 2) == 0)
      write_reg(CfgIdxW'($urandom_range(CfgIdxFirstSpare, (1 << CfgIdxW) - 1)),
                CfgDatW'($urandom));
  endtask

  task automatic test_reset_defaults();
    bursty = 1'b0;
    send_sample(16'h0000, 16'h0000);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h0001, 16'hffff);
    send_sample(16'h0000, 16'h0000);
    send_sample(PosW'(-2000), PosW'(2000));
    wait_drained();
  endtask

  task automatic test_output_extremes();
    apply_config(GainMax, GainMax, GainMax, ILimMax, OLimMax, 1'b0);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h7fff);
    wait_drained();
  endtask

  task automatic test_floor_rounding();
    apply_config(1, 0, 0, ILimMax, OLimMax, 1'b0);
    send_sample(16'h0001, 16'hffff);
    send_sample(16'h0007, PosW'(-7));
    send_sample(16'h8000, 16'h7fff);
    wait_drained();
  endtask

  task automatic test_integral_clamp();
    apply_config(0, GainMax, 0, 3, OLimMax, 1'b0);
    send_sample(PosW'(-2), PosW'(2));
    send_sample(PosW'(-2), PosW'(2));
    send_sample(PosW'(-2), PosW'(2));
    send_sample(PosW'(2), PosW'(-2));
    send_sample(PosW'(2), PosW'(-2));
    wait_drained();
    // integral pinned at zero
    write_reg(dapc_pkg::CFG_INTEG_LIM, '0);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h7fff, 16'h8000);
    wait_drained();
  endtask

  task automatic test_zero_output_limit();
    apply_config(GainMax, GainMax, GainMax, ILimMax, 0, 1'b0);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    wait_drained();
  endtask

  task automatic test_register_masking();
    write_reg(dapc_pkg::CFG_GAIN_P, 21'h1c_0001 | CfgDatW'(65536));
    write_reg(dapc_pkg::CFG_GAIN_I, 21'h1c_0000);
    write_reg(dapc_pkg::CFG_GAIN_D, 21'h1f_ffff);
    write_reg(dapc_pkg::CFG_INTEG_LIM, 21'h00_1000);
    write_reg(dapc_pkg::CFG_OUTPUT_LIM, 21'h1f_8000 | CfgDatW'(300));
    for (int k = CfgIdxFirstSpare; k < (1 << CfgIdxW); k++)
      write_reg(CfgIdxW'(k), '1);
    send_sample(PosW'(-100), PosW'(100));
    send_sample(PosW'(50), PosW'(-50));
    send_sample(16'h0000, 16'h0000);
    wait_drained();
  endtask

  task automatic test_random_phases(input int total);
    int per;
    per = total / RandomPhases;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      bursty = (ph % 4 != 3);
      if (ph == 0)
        apply_config(GainMax, GainMax, GainMax, ILimMax, OLimMax, 1'b1);
      else if (ph == 1)
        apply_config(0, 0, 0, 0, 0, 1'b1);
      else if (ph == 2)
        apply_config(dapc_pkg::GainPRst, dapc_pkg::GainIRst, dapc_pkg::GainDRst,
                     dapc_pkg::ILimRst, dapc_pkg::OLimRst, 1'b0);
      else
        apply_config(pick_reg(GainMax, dapc_pkg::GainPRst),
                     pick_reg(GainMax, dapc_pkg::GainIRst),
                     pick_reg(GainMax, dapc_pkg::GainDRst),
                     pick_reg(ILimMax, dapc_pkg::ILimRst),
                     pick_reg(OLimMax, dapc_pkg::OLimRst), 1'b1);
      for (int i = 0; i < per; i++) begin
        if (ph % 2 == 1 && i == per / 2) wait_drained();
        send_sample(rand_pos(walk_x), rand_pos(walk_y));
      end
      wait_drained();
    end
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      drive_pair_t want;
      result_cnt++;
      if (drive_q.size() == 0) begin
        $display("%0t: unexpected result drive_x=%0d drive_y=%0d", $time,
                 $signed(drive_x_o), $signed(drive_y_o));
        fail_cnt++;
      end else begin
        want = drive_q.pop_front();
        if (drive_x_o !== want.dx) begin
          $display("%0t: drive_x mismatch, expected %0d, actual %0d", $time,
                   $signed(want.dx), $signed(drive_x_o));
          fail_cnt++;
        end
        if (drive_y_o !== want.dy) begin
          $display("%0t: drive_y mismatch, expected %0d, actual %0d", $time,
                   $signed(want.dy), $signed(drive_y_o));
          fail_cnt++;
        end
      end
    end
  end

  // output backpressure
  initial begin
    int run;
    bit hold;
    run = 0;
    hold = 1'b0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!bursty) begin
        out_ready_i <= 1'b1;
      end else begin
        if (run == 0) begin
          hold = ($urandom_range(0, 99) < 35);
          if (!hold) run = $urandom_range(1, 12);
          else if ($urandom_range(0, 9) == 0) run = $urandom_range(8, 30);
          else run = $urandom_range(1, 3);
        end
        run--;
        out_ready_i <= !hold;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= StuckLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, stuck_cycles);
      $display("FAIL dual_axis_pid_clamped");
      $finish;
    end
  end

  initial begin
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    pos_x_i <= '0;
    pos_y_i <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= dapc_pkg::CFG_GAIN_P;
    cfg_data_i <= '0;
    cfg_kp = dapc_pkg::GainPRst;
    cfg_ki = dapc_pkg::GainIRst;
    cfg_kd = dapc_pkg::GainDRst;
    cfg_ilim = dapc_pkg::ILimRst;
    cfg_olim = dapc_pkg::OLimRst;
    hist_x = '{default: '0};
    hist_y = '{default: '0};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_output_extremes();
    test_floor_rounding();
    test_integral_clamp();
    test_zero_output_limit();
    test_register_masking();
    test_random_phases(RandomSamples);

    wait_drained();
    repeat (12) @(posedge clk_i);
    $display("run covered %0d samples, %0d results and %0d register writes", sample_cnt,
             result_cnt, cfg_write_cnt);
    $display("configs included all-max, all-zero, defaults and random gains and clamps");
    if (fail_cnt == 0)
      $display("PASS dual_axis_pid_clamped");
    else
      $display("FAIL dual_axis_pid_clamped");
    $finish;
  end

endmodule
